/* rtl/sgpi_pkg.sv */
// Shared types, constants and arithmetic helpers of the staggered-grid interpolator.
package sgpi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW = 32;
  localparam int CW = FRAC_BITS + 4;
  localparam int WW = FRAC_BITS + 5;
  localparam int PXW = 2 * DW + 1;
  localparam int SW = PXW - FRAC_BITS + 1;
  localparam int PW = WW + DW;
  localparam int RW = PW + 2 - FRAC_BITS;
  localparam int QW = WW + RW;

  localparam longint ONE_FX = longint'(1) << FRAC_BITS;
  localparam longint HALF_FX = longint'(1) << (FRAC_BITS - 1);
  localparam longint RC_LIMIT = longint'(4) << FRAC_BITS;

  localparam logic [2:0] ZONE_OUT = 3'd0;
  localparam logic [2:0] ZONE_LL = 3'd1;
  localparam logic [2:0] ZONE_LR = 3'd2;
  localparam logic [2:0] ZONE_UL = 3'd3;
  localparam logic [2:0] ZONE_UR = 3'd4;
  localparam logic [2:0] ZONE_HALO = 3'd5;

  typedef enum logic [1:0] {
    REQ_P_BILIN = 2'd0,
    REQ_P_BARY = 2'd1,
    REQ_U = 2'd2,
    REQ_V = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_UNSUP = 2'd2,
    ST_SAT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_CELL_X = 2'd0,
    CFG_CELL_Y = 2'd1,
    CFG_INV_X = 2'd2,
    CFG_INV_Y = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    req_kind_t req_type;
    logic signed [DW-1:0] offset_x;
    logic signed [DW-1:0] offset_y;
    logic signed [DW-1:0] cell_value;
    logic signed [DW-1:0] vertex0_a;
    logic signed [DW-1:0] vertex0_b;
    logic signed [DW-1:0] vertex1_a;
    logic signed [DW-1:0] vertex1_b;
    logic signed [DW-1:0] vertex2_a;
    logic signed [DW-1:0] vertex2_b;
    logic signed [DW-1:0] vertex3_a;
    logic signed [DW-1:0] vertex3_b;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] interp_value;
    logic [2:0] zone;
    status_t status;
  } out_t;

  typedef struct packed {
    logic [DW-2:0] cell_size_x;
    logic [DW-2:0] cell_size_y;
    logic [DW-1:0] inv_cell_size_x;
    logic [DW-1:0] inv_cell_size_y;
  } cfg_t;

  typedef struct packed {
    logic bary;
    logic [2:0] zone;
    status_t status;
    logic sat;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [DW-1:0] p0;
    logic signed [DW-1:0] p1;
    logic signed [DW-1:0] p2;
    logic signed [DW-1:0] p3;
  } job_t;

  typedef struct packed {
    logic hit;
    logic signed [DW-1:0] v;
  } sat_t;

  typedef struct packed {
    logic hit;
    logic signed [CW-1:0] v;
  } clamp_t;

  function automatic sat_t sat_wide(input logic signed [DW+3:0] v);
    sat_t r;
    r.hit = 1'b1;
    if (v > (DW+4)'(64'sh7FFF_FFFF)) begin
      r.v = 32'sh7FFF_FFFF;
    end else if (v < -(DW+4)'(64'sh8000_0000)) begin
      r.v = 32'sh8000_0000;
    end else begin
      r.hit = 1'b0;
      r.v = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic sat_t mirror2(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
    logic signed [DW+3:0] t;
    t = ((DW+4)'(a) <<< 1) - (DW+4)'(b);
    return sat_wide(t);
  endfunction

  function automatic sat_t mirror4(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
                                   input logic signed [DW-1:0] c, input logic signed [DW-1:0] d);
    logic signed [DW+3:0] t;
    t = ((DW+4)'(a) <<< 2) - (DW+4)'(b) - (DW+4)'(c) - (DW+4)'(d);
    return sat_wide(t);
  endfunction

  function automatic clamp_t clamp_rc(input logic signed [SW-1:0] v);
    clamp_t r;
    r.hit = 1'b1;
    if (v > SW'(RC_LIMIT)) begin
      r.v = CW'(RC_LIMIT);
    end else if (v < -SW'(RC_LIMIT)) begin
      r.v = -CW'(RC_LIMIT);
    end else begin
      r.hit = 1'b0;
      r.v = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/sgpi_front.sv */
// Front end: zone classification, coordinate scaling and corner mirroring.
module sgpi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  sgpi_pkg::in_t   req,
  input  sgpi_pkg::cfg_t  cfg,
  output logic            push,
  output sgpi_pkg::job_t  job
);
  import sgpi_pkg::*;

  logic f1_valid;
  in_t f1_req;
  logic [2:0] f1_zone;
  logic signed [PXW-1:0] f1_px;
  logic signed [PXW-1:0] f1_py;

  logic signed [DW+1:0] ox, oy, cx, cy;
  logic outside, halo;
  logic [2:0] zone_c;

  always_comb begin
    ox = (DW+2)'(req.offset_x);
    oy = (DW+2)'(req.offset_y);
    cx = $signed({3'b000, cfg.cell_size_x});
    cy = $signed({3'b000, cfg.cell_size_y});
    outside = ox < 0 || ox > cx || oy < 0 || oy > cy;
    halo = ((ox <<< 1) > -cx) && ox <= 0 && ((oy <<< 1) > -cy) && oy <= 0;
    if (outside) begin
      zone_c = halo ? ZONE_HALO : ZONE_OUT;
    end else if ((ox <<< 1) <= cx) begin
      zone_c = ((oy <<< 1) <= cy) ? ZONE_LL : ZONE_UL;
    end else begin
      zone_c = ((oy <<< 1) <= cy) ? ZONE_LR : ZONE_UR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
    if (accept) begin
      f1_req <= req;
      f1_zone <= zone_c;
      f1_px <= PXW'($signed(req.offset_x) * $signed({1'b0, cfg.inv_cell_size_x}));
      f1_py <= PXW'($signed(req.offset_y) * $signed({1'b0, cfg.inv_cell_size_y}));
    end
  end

  logic signed [PXW-1:0] rx, ry;
  logic signed [SW-1:0] sxv, syv, xr, yr;
  logic signed [DW-1:0] c, p0, p1, p2, p3;
  logic sat, unsup, right, upper;
  sat_t t;
  clamp_t kx, ky;

  always_comb begin
    rx = f1_px + PXW'(HALF_FX);
    ry = f1_py + PXW'(HALF_FX);
    sxv = SW'($signed(rx[PXW-1:FRAC_BITS]));
    syv = SW'($signed(ry[PXW-1:FRAC_BITS]));
    c = f1_req.cell_value;
    sat = 1'b0;
    unsup = 1'b0;
    xr = '0;
    yr = '0;
    p0 = '0;
    p1 = '0;
    p2 = '0;
    p3 = '0;
    t = '0;
    right = f1_zone == ZONE_LR || f1_zone == ZONE_UR;
    upper = f1_zone == ZONE_UL || f1_zone == ZONE_UR;
    if (f1_req.req_type == REQ_P_BILIN) begin
      if (f1_zone == ZONE_LL || f1_zone == ZONE_HALO) begin
        xr = sxv + SW'(HALF_FX);
        yr = syv + SW'(HALF_FX);
        p3 = c;
        t = mirror2(f1_req.vertex2_b, c); p2 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex1_a, c); p1 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex0_b, p1); p0 = t.v; sat = sat | t.hit;
      end else if (f1_zone == ZONE_LR) begin
        xr = sxv - SW'(HALF_FX);
        yr = syv + SW'(HALF_FX);
        p2 = c;
        t = mirror2(f1_req.vertex1_a, c); p0 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex3_b, c); p3 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex1_b, p0); p1 = t.v; sat = sat | t.hit;
      end else if (f1_zone == ZONE_UL) begin
        xr = sxv + SW'(HALF_FX);
        yr = syv - SW'(HALF_FX);
        p1 = c;
        t = mirror2(f1_req.vertex2_b, c); p0 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex3_a, c); p3 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex2_a, p0); p2 = t.v; sat = sat | t.hit;
      end else begin
        unsup = 1'b1;
      end
    end else if (f1_zone == ZONE_HALO) begin
      unsup = 1'b1;
    end else if (f1_req.req_type == REQ_P_BARY) begin
      xr = right ? sxv - SW'(HALF_FX) : SW'(HALF_FX) - sxv;
      yr = upper ? syv - SW'(HALF_FX) : SW'(HALF_FX) - syv;
      p0 = c;
      t = mirror2(right ? f1_req.vertex3_b : f1_req.vertex2_b, c); p1 = t.v; sat = sat | t.hit;
      t = mirror2(upper ? f1_req.vertex3_a : f1_req.vertex1_a, c); p2 = t.v; sat = sat | t.hit;
    end else if (f1_req.req_type == REQ_U) begin
      xr = sxv;
      if (!upper) begin
        yr = syv + SW'(HALF_FX);
        p3 = c;
        t = mirror2(f1_req.vertex2_a, c); p2 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex1_a, c); p1 = t.v; sat = sat | t.hit;
        t = mirror4(f1_req.vertex0_a, p1, p2, p3); p0 = t.v; sat = sat | t.hit;
      end else begin
        yr = syv - SW'(HALF_FX);
        p1 = c;
        t = mirror2(f1_req.vertex2_a, c); p0 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex3_a, c); p3 = t.v; sat = sat | t.hit;
        t = mirror4(f1_req.vertex2_b, p0, p1, p3); p2 = t.v; sat = sat | t.hit;
      end
    end else begin
      yr = syv;
      if (!right) begin
        xr = sxv + SW'(HALF_FX);
        p3 = c;
        t = mirror2(f1_req.vertex2_a, c); p2 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex1_a, c); p1 = t.v; sat = sat | t.hit;
        t = mirror4(f1_req.vertex0_a, p1, p2, p3); p0 = t.v; sat = sat | t.hit;
      end else begin
        xr = sxv - SW'(HALF_FX);
        p2 = c;
        t = mirror2(f1_req.vertex1_a, c); p0 = t.v; sat = sat | t.hit;
        t = mirror2(f1_req.vertex3_a, c); p3 = t.v; sat = sat | t.hit;
        t = mirror4(f1_req.vertex1_b, p0, p2, p3); p1 = t.v; sat = sat | t.hit;
      end
    end
    kx = clamp_rc(xr);
    ky = clamp_rc(yr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= f1_valid;
    end
    if (f1_valid) begin
      job.bary <= f1_req.req_type == REQ_P_BARY;
      job.zone <= f1_zone;
      if (f1_zone == ZONE_OUT) begin
        job.status <= ST_OUTSIDE;
      end else if (unsup) begin
        job.status <= ST_UNSUP;
      end else begin
        job.status <= ST_OK;
      end
      job.sat <= sat | kx.hit | ky.hit;
      job.x <= kx.v;
      job.y <= ky.v;
      job.p0 <= p0;
      job.p1 <= p1;
      job.p2 <= p2;
      job.p3 <= p3;
    end
  end

endmodule

/* rtl/sgpi_queue.sv */
// Short word queue between the front end and the weighting back end.
module sgpi_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sgpi_pkg::job_t  push_job,
  output logic            pop,
  output sgpi_pkg::job_t  pop_job,
  output logic            nearly_full
);
  import sgpi_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign pop = count != '0;
  assign pop_job = mem[rd_ptr];
  assign nearly_full = count > NW'(DEPTH - 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + NW'(push) - NW'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

/* rtl/sgpi_back.sv */
// Back end: pipelined bilinear or barycentric weighted sum with saturation.
module sgpi_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  sgpi_pkg::job_t  job,
  output logic            done,
  output sgpi_pkg::out_t  res
);
  import sgpi_pkg::*;

  typedef struct packed {
    logic bary;
    logic [2:0] zone;
    status_t status;
    logic sat;
  } tag_t;

  logic b1_valid, b2_valid, b3_valid;
  tag_t b1_tag, b2_tag, b3_tag;
  logic signed [PW-1:0] m0, m1, m2, m3;
  logic signed [CW-1:0] b1_y, b2_y;
  logic signed [RW-1:0] r0, r1;
  logic signed [QW-1:0] q0, q1;

  logic signed [WW-1:0] wx, wy, w0, w1, w2, w3;
  always_comb begin
    wx = WW'(ONE_FX) - WW'(job.x);
    wy = WW'(ONE_FX) - WW'(job.y);
    if (job.bary) begin
      w0 = wx - WW'(job.y);
      w2 = WW'(job.y);
      w3 = '0;
    end else begin
      w0 = wx;
      w2 = wx;
      w3 = WW'(job.x);
    end
    w1 = WW'(job.x);
  end

  logic signed [PW+1:0] s0, s1;
  always_comb begin
    if (b1_tag.bary) begin
      s0 = (PW+2)'(m0) + (PW+2)'(m1) + (PW+2)'(m2) + (PW+2)'(HALF_FX);
    end else begin
      s0 = (PW+2)'(m0) + (PW+2)'(m1) + (PW+2)'(HALF_FX);
    end
    s1 = (PW+2)'(m2) + (PW+2)'(m3) + (PW+2)'(HALF_FX);
  end

  logic signed [QW:0] s2;
  logic signed [QW-FRAC_BITS:0] fin;
  logic signed [DW+3:0] fin_n;
  sat_t fs;
  always_comb begin
    s2 = (QW+1)'(q0) + (QW+1)'(q1) + (QW+1)'(HALF_FX);
    fin = s2[QW:FRAC_BITS];
    if (fin > (QW-FRAC_BITS+1)'(64'sh7FFF_FFFF)) begin
      fin_n = (DW+4)'(64'sh7FFF_FFFF) + (DW+4)'(1);
    end else if (fin < -(QW-FRAC_BITS+1)'(64'sh8000_0000)) begin
      fin_n = -(DW+4)'(64'sh8000_0000) - (DW+4)'(1);
    end else begin
      fin_n = (DW+4)'(fin);
    end
    fs = sat_wide(fin_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      b1_valid <= take;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      done <= b3_valid;
    end
    if (take) begin
      b1_tag <= '{bary: job.bary, zone: job.zone, status: job.status, sat: job.sat};
      m0 <= PW'(w0 * job.p0);
      m1 <= PW'(w1 * job.p1);
      m2 <= PW'(w2 * job.p2);
      m3 <= PW'(w3 * job.p3);
      b1_y <= job.y;
    end
    if (b1_valid) begin
      b2_tag <= b1_tag;
      r0 <= s0[PW+1:FRAC_BITS];
      r1 <= s1[PW+1:FRAC_BITS];
      b2_y <= b1_y;
    end
    if (b2_valid) begin
      b3_tag <= b2_tag;
      if (b2_tag.bary) begin
        q0 <= QW'(r0) <<< FRAC_BITS;
        q1 <= '0;
      end else begin
        q0 <= QW'((WW'(ONE_FX) - WW'(b2_y)) * r0);
        q1 <= QW'(WW'(b2_y) * r1);
      end
    end
    if (b3_valid) begin
      res.zone <= b3_tag.zone;
      if (b3_tag.status != ST_OK) begin
        res.interp_value <= '0;
        res.status <= b3_tag.status;
      end else begin
        res.interp_value <= fs.v;
        res.status <= (b3_tag.sat || fs.hit) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

/* rtl/staggered_grid_point_interpolator_core.sv */
// Top level: configuration registers, front end, word queue and back end.
// From start to done a query passes 2 front, 1 queue and 4 back stages.
// Throughput: one query per cycle while busy is low, set by the single-pass front and back pipelines.
// busy stays low with the default QUEUE_DEPTH: the back end drains the queue every cycle.
// Synchronous reset clears pipeline valids and the queue; cell sizes and reciprocals reset to 1.0.
// Results appear for one cycle on done; the receiver cannot stall.
module staggered_grid_point_interpolator_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sgpi_pkg::in_t       req,
  output logic                done,
  output sgpi_pkg::out_t      res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  sgpi_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_data
);
  import sgpi_pkg::*;

  cfg_t cfg;
  logic accept, push, pop, nearly_full;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;
  assign busy = nearly_full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size_x <= (DW-1)'(ONE_FX);
      cfg.cell_size_y <= (DW-1)'(ONE_FX);
      cfg.inv_cell_size_x <= DW'(ONE_FX);
      cfg.inv_cell_size_y <= DW'(ONE_FX);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CELL_X: cfg.cell_size_x <= cfg_data[DW-2:0];
        CFG_CELL_Y: cfg.cell_size_y <= cfg_data[DW-2:0];
        CFG_INV_X: cfg.inv_cell_size_x <= cfg_data;
        CFG_INV_Y: cfg.inv_cell_size_y <= cfg_data;
        default: ;
      endcase
    end
  end

  sgpi_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .req(req), .cfg(cfg),
    .push(push), .job(push_job)
  );

  sgpi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job),
    .pop(pop), .pop_job(pop_job), .nearly_full(nearly_full)
  );

  sgpi_back u_back (
    .clk(clk), .rst(rst), .take(pop), .job(pop_job), .done(done), .res(res)
  );

endmodule

/* tb/staggered_grid_point_interpolator_core_test.sv */
// Self-checking test of the staggered-grid interpolator: directed table, random queries, config phases.
module staggered_grid_point_interpolator_core_test;
  import sgpi_pkg::*;

  localparam int WATCHDOG = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t req = '0;
  logic done;
  out_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_CELL_X;
  logic [31:0] cfg_data = '0;

  staggered_grid_point_interpolator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  longint size_x, size_y, recip_x, recip_y;
  out_t pending_words[$];
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic longint fdiv(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint rnd(longint v);
    return fdiv(v + HALF_FX);
  endfunction

  function automatic longint sat_word(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin hit = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin hit = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint clip_coord(longint v, ref bit hit);
    if (v > RC_LIMIT) begin hit = 1; return RC_LIMIT; end
    if (v < -RC_LIMIT) begin hit = 1; return -RC_LIMIT; end
    return v;
  endfunction

  function automatic longint refl(longint a, longint b, ref bit hit);
    return sat_word(2 * a - b, hit);
  endfunction

  function automatic longint refl4(longint a, longint b, longint c, longint d, ref bit hit);
    return sat_word(4 * a - b - c - d, hit);
  endfunction

  function automatic logic [2:0] zone_of(longint ox, longint oy);
    if (ox < 0 || ox > size_x || oy < 0 || oy > size_y) begin
      if (2 * ox > -size_x && ox <= 0 && 2 * oy > -size_y && oy <= 0) return ZONE_HALO;
      return ZONE_OUT;
    end
    if (2 * ox <= size_x) return (2 * oy <= size_y) ? ZONE_LL : ZONE_UL;
    return (2 * oy <= size_y) ? ZONE_LR : ZONE_UR;
  endfunction

  function automatic out_t interpolate(in_t q);
    out_t o;
    bit hit, unsup, right, upper;
    longint ox, oy, c, sx, sy, x, y, r0, r1, v;
    longint p[4];
    logic [2:0] z;
    ox = q.offset_x; oy = q.offset_y; c = q.cell_value;
    z = zone_of(ox, oy);
    hit = 0; unsup = 0; x = 0; y = 0; p = '{0, 0, 0, 0};
    sx = rnd(ox * recip_x);
    sy = rnd(oy * recip_y);
    o.zone = z;
    if (z == ZONE_OUT) begin
      o.interp_value = '0; o.status = ST_OUTSIDE;
      return o;
    end
    if (q.req_type == REQ_P_BILIN) begin
      if (z == ZONE_LL || z == ZONE_HALO) begin
        x = sx + HALF_FX; y = sy + HALF_FX;
        p[3] = c; p[2] = refl(q.vertex2_b, c, hit);
        p[1] = refl(q.vertex1_a, c, hit); p[0] = refl(q.vertex0_b, p[1], hit);
      end else if (z == ZONE_LR) begin
        x = sx - HALF_FX; y = sy + HALF_FX;
        p[2] = c; p[0] = refl(q.vertex1_a, c, hit);
        p[3] = refl(q.vertex3_b, c, hit); p[1] = refl(q.vertex1_b, p[0], hit);
      end else if (z == ZONE_UL) begin
        x = sx + HALF_FX; y = sy - HALF_FX;
        p[1] = c; p[0] = refl(q.vertex2_b, c, hit);
        p[3] = refl(q.vertex3_a, c, hit); p[2] = refl(q.vertex2_a, p[0], hit);
      end else unsup = 1;
    end else if (z == ZONE_HALO) begin
      unsup = 1;
    end else if (q.req_type == REQ_P_BARY) begin
      right = (z == ZONE_LR || z == ZONE_UR);
      upper = (z == ZONE_UL || z == ZONE_UR);
      x = right ? sx - HALF_FX : HALF_FX - sx;
      y = upper ? sy - HALF_FX : HALF_FX - sy;
      p[0] = c;
      p[1] = refl(right ? q.vertex3_b : q.vertex2_b, c, hit);
      p[2] = refl(upper ? q.vertex3_a : q.vertex1_a, c, hit);
    end else if (q.req_type == REQ_U) begin
      x = sx;
      if (z <= ZONE_LR) begin
        y = sy + HALF_FX;
        p[3] = c; p[2] = refl(q.vertex2_a, c, hit); p[1] = refl(q.vertex1_a, c, hit);
        p[0] = refl4(q.vertex0_a, p[1], p[2], p[3], hit);
      end else begin
        y = sy - HALF_FX;
        p[1] = c; p[0] = refl(q.vertex2_a, c, hit); p[3] = refl(q.vertex3_a, c, hit);
        p[2] = refl4(q.vertex2_b, p[0], p[1], p[3], hit);
      end
    end else begin
      y = sy;
      if (z == ZONE_LL || z == ZONE_UL) begin
        x = sx + HALF_FX;
        p[3] = c; p[2] = refl(q.vertex2_a, c, hit); p[1] = refl(q.vertex1_a, c, hit);
        p[0] = refl4(q.vertex0_a, p[1], p[2], p[3], hit);
      end else begin
        x = sx - HALF_FX;
        p[2] = c; p[0] = refl(q.vertex1_a, c, hit); p[3] = refl(q.vertex3_a, c, hit);
        p[1] = refl4(q.vertex1_b, p[0], p[2], p[3], hit);
      end
    end
    if (unsup) begin
      o.interp_value = '0; o.status = ST_UNSUP;
      return o;
    end
    x = clip_coord(x, hit);
    y = clip_coord(y, hit);
    if (q.req_type == REQ_P_BARY) begin
      v = rnd((ONE_FX - x - y) * p[0] + x * p[1] + y * p[2]);
    end else begin
      r0 = rnd((ONE_FX - x) * p[0] + x * p[1]);
      r1 = rnd((ONE_FX - x) * p[2] + x * p[3]);
      v = rnd((ONE_FX - y) * r0 + y * r1);
    end
    v = sat_word(v, hit);
    o.interp_value = v[31:0];
    o.status = hit ? ST_SAT : ST_OK;
    return o;
  endfunction

  // check results
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      idle_cycles <= (done || (start && !busy) || (cfg_valid && cfg_ready)) ? 0 : idle_cycles + 1;
      if (done) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", res);
        end else begin
          want = pending_words.pop_front();
          if (res.interp_value !== want.interp_value || res.zone !== want.zone ||
              res.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected val %h zone %0d st %0d, got val %h zone %0d st %0d",
                       want.interp_value, want.zone, want.status,
                       res.interp_value, res.zone, res.status);
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CELL_X: size_x = data[30:0];
      CFG_CELL_Y: size_y = data[30:0];
      CFG_INV_X:  recip_x = data;
      default:    recip_y = data;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_cell(logic [31:0] cx, logic [31:0] cy, logic [31:0] ix, logic [31:0] iy);
    drain();
    write_reg(CFG_CELL_X, cx);
    write_reg(CFG_CELL_Y, cy);
    write_reg(CFG_INV_X, ix);
    write_reg(CFG_INV_Y, iy);
  endtask

  // send one query; hold start across back-to-back words
  task automatic send_query(in_t q, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start <= 1'b1; req <= q;
    do @(posedge clk); while (busy);
    pending_words.push_back(interpolate(q));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // point mostly in or near the cell
  function automatic logic [31:0] rand_offset(longint extent);
    longint span;
    span = (extent < 64) ? 64 : extent;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 0;
      2: return extent[31:0];
      3: return 32'($urandom_range(0, 31'(span / 2)) * -1);
      default: return 32'($urandom_range(0, 31'(span)));
    endcase
  endfunction

  function automatic in_t rand_query(bit full_rand);
    in_t q;
    q.req_type = req_kind_t'($urandom_range(0, 3));
    q.offset_x = full_rand ? $urandom() : rand_offset(size_x);
    q.offset_y = full_rand ? $urandom() : rand_offset(size_y);
    q.cell_value = rand_word();
    q.vertex0_a = rand_word(); q.vertex0_b = rand_word();
    q.vertex1_a = rand_word(); q.vertex1_b = rand_word();
    q.vertex2_a = rand_word(); q.vertex2_b = rand_word();
    q.vertex3_a = rand_word(); q.vertex3_b = rand_word();
    return q;
  endfunction

  typedef struct {
    req_kind_t kind;
    logic [31:0] ox, oy, val;
    bit typed;
    out_t want;
  } row_t;

  row_t rows[$];
  in_t q;
  out_t plain;

  initial begin
    size_x = 65536; size_y = 65536; recip_x = 65536; recip_y = 65536;
    rows = '{
      '{REQ_P_BILIN, 32'h0000_4000, 32'h0000_4000, 32'h0001_0000, 1, '{32'h0001_0000, ZONE_LL, ST_OK}},
      '{REQ_P_BILIN, 32'h0000_C000, 32'h0000_C000, 32'h0001_0000, 1, '{32'h0, ZONE_UR, ST_UNSUP}},
      '{REQ_U, 32'hFFFF_C000, 32'hFFFF_C000, 32'h0001_0000, 1, '{32'h0, ZONE_HALO, ST_UNSUP}},
      '{REQ_P_BARY, 32'hFFFF_0000, 32'h0, 32'h0, 1, '{32'h0, ZONE_OUT, ST_OUTSIDE}},
      '{REQ_V, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1, '{32'h0, ZONE_OUT, ST_OUTSIDE}},
      '{REQ_P_BILIN, 32'hFFFF_C000, 32'hFFFF_C000, 32'h7FFF_FFFF, 0, '0},
      '{REQ_P_BILIN, 32'h0000_C000, 32'h0000_4000, 32'h8000_0000, 0, '0},
      '{REQ_P_BILIN, 32'h0000_4000, 32'h0000_C000, 32'h0002_0000, 0, '0},
      '{REQ_P_BARY, 32'h0000_4000, 32'h0000_4000, 32'h0001_0000, 0, '0},
      '{REQ_P_BARY, 32'h0000_C000, 32'h0000_C000, 32'h7FFF_FFFF, 0, '0},
      '{REQ_P_BARY, 32'h0000_8000, 32'h0001_0000, 32'h8000_0000, 0, '0},
      '{REQ_U, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 0, '0},
      '{REQ_U, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 0, '0},
      '{REQ_U, 32'h0000_C000, 32'h0000_4000, 32'h8000_0000, 0, '0},
      '{REQ_V, 32'h0000_4000, 32'h0000_C000, 32'h0001_8000, 0, '0},
      '{REQ_V, 32'h0000_C000, 32'h0000_C000, 32'h7FFF_FFFF, 0, '0},
      '{REQ_V, 32'hFFFF_C000, 32'h0000_0000, 32'h8000_0000, 0, '0},
      '{REQ_P_BARY, 32'hFFFF_8001, 32'hFFFF_8001, 32'h0001_0000, 1,
        '{32'h0, ZONE_HALO, ST_UNSUP}}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      q = '0;
      q.req_type = rows[i].kind; q.offset_x = rows[i].ox; q.offset_y = rows[i].oy;
      q.cell_value = rows[i].val;
      if (i < 5) begin
        q.vertex0_a = rows[i].val; q.vertex0_b = rows[i].val; q.vertex1_a = rows[i].val;
        q.vertex1_b = rows[i].val; q.vertex2_a = rows[i].val; q.vertex2_b = rows[i].val;
        q.vertex3_a = rows[i].val; q.vertex3_b = rows[i].val;
      end else begin
        q.vertex0_a = 32'h7FFF_FFFF; q.vertex0_b = 32'h8000_0000;
        q.vertex1_a = 32'h8000_0000; q.vertex1_b = 32'h7FFF_FFFF;
        q.vertex2_a = 32'h0001_0000; q.vertex2_b = 32'hFFFF_0000;
        q.vertex3_a = 32'h7FFF_FFFF; q.vertex3_b = 32'h8000_0000;
      end
      send_query(q, i % 3);
      if (rows[i].typed) begin
        plain = pending_words.pop_back();
        pending_words.push_back(rows[i].want);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        1: set_cell(32'h0002_0000, 32'h0000_8000, 32'h0000_8000, 32'h0002_0000);
        2: set_cell(32'h0, 32'h0, 32'h0, 32'h0);
        3: set_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: set_cell(32'h0000_0001, 32'h0000_0003, 32'h0000_0001, 32'h8000_0000);
        5: set_cell($urandom_range(1, 32'h0010_0000), $urandom_range(1, 32'h0010_0000),
                    $urandom(), $urandom());
        default: set_cell(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0000_4000);
      endcase
      for (int n = 0; n < 250; n++) begin
        if (n == 120) drain();
        q = rand_query($urandom_range(0, 9) == 0);
        send_query(q, (n % 50 < 15) ? 0 : $urandom_range(0, 19));
      end
      @(negedge clk);
      start <= 1'b0;
    end

    drain();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sgpi_pkg.sv
rtl/sgpi_front.sv
rtl/sgpi_queue.sv
rtl/sgpi_back.sv
rtl/staggered_grid_point_interpolator_core.sv
tb/staggered_grid_point_interpolator_core_test.sv
